// File: src/ir_pulse_capture_replay_assert.svh
// ----------------------------------------------------------------------------
// ir_pulse_capture_replay_assert.svh
// Assertion macros used by the pulse capture and replay RTL.
// ----------------------------------------------------------------------------
`ifndef IR_PULSE_CAPTURE_REPLAY_ASSERT_SVH
`define IR_PULSE_CAPTURE_REPLAY_ASSERT_SVH

// Checks a condition at every clock edge outside of reset.
`define IRPCR_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next cycle.
`define IRPCR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: src/irpcr_pkg.sv
// ----------------------------------------------------------------------------
// irpcr_pkg
// Types and constants of the IR pulse capture and replay block.
// ----------------------------------------------------------------------------
package irpcr_pkg;

  localparam int STORE_DEPTH_DEF   = 1024;
  localparam int INTERVAL_BITS_DEF = 24;

  localparam int TIMEOUT_W  = 24;
  localparam int INTERVAL_W = 24;
  localparam int COUNT_W    = 11;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 24'd1000000;

  typedef enum logic [1:0] {
    MODE_ARM    = 2'd0,
    MODE_CAP    = 2'd1,
    MODE_REPLAY = 2'd2,
    MODE_RTICK  = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t mode;
    logic  pin_level;
  } in_item_t;

  typedef struct packed {
    logic                  pin_out;
    logic [INTERVAL_W-1:0] interval;
    logic                  interval_valid;
    logic                  capture_done;
    logic                  replay_done;
    logic [COUNT_W-1:0]    stored_count;
    logic                  overflow;
  } out_item_t;

endpackage

// File: src/irpcr_ram.sv
// ----------------------------------------------------------------------------
// irpcr_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module irpcr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/ir_pulse_capture_replay.sv
// ----------------------------------------------------------------------------
// ir_pulse_capture_replay
// Records the tick intervals between receiver edges into an interval memory
// and replays them as a toggling emitter level.
// ----------------------------------------------------------------------------
//  Channel  Ports                          Direction  Content
//  in       in_valid, in_ready, in_data    sink       mode, pin_level
//  out      out_valid, out_ready, out_data sink->src  one result per item
//  cfg      cfg_we, cfg_wdata              sink       idle_timeout_ticks
//
// Every item yields one result in the output register on the following cycle;
// an item can be accepted in every cycle unless a result waits stalled.
// The interval memory is read one entry ahead during replay, so its registered
// read latency is hidden; the first entry is also kept in a register.
// Reset is synchronous; the interval memory is not cleared.
// in_ready drops only while a result waits in the output register and
// out_ready is low.
// ----------------------------------------------------------------------------
`include "ir_pulse_capture_replay_assert.svh"

module ir_pulse_capture_replay #(
  parameter int STORE_DEPTH   = irpcr_pkg::STORE_DEPTH_DEF,
  parameter int INTERVAL_BITS = irpcr_pkg::INTERVAL_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  irpcr_pkg::in_item_t              in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output irpcr_pkg::out_item_t             out_data,
  input  logic                             cfg_we,
  input  logic [irpcr_pkg::TIMEOUT_W-1:0]  cfg_wdata
);

  localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam logic [INTERVAL_BITS-1:0] TICK_MAX = {INTERVAL_BITS{1'b1}};
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STORE_DEPTH);

  logic                          last_level_r, last_level_nxt;
  logic                          scanning_r, scanning_nxt;
  logic                          capture_active_r, capture_active_nxt;
  logic [INTERVAL_BITS-1:0]      tick_r, tick_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [CNT_W-1:0]              ridx_r, ridx_nxt;
  logic [INTERVAL_BITS-1:0]      rem_r, rem_nxt;
  logic                          replay_active_r, replay_active_nxt;
  logic                          out_level_r, out_level_nxt;
  logic                          overflow_r, overflow_nxt;
  logic [INTERVAL_BITS-1:0]      entry0_r, entry0_nxt;
  logic [irpcr_pkg::TIMEOUT_W-1:0] timeout_r;
  logic                          out_valid_r;
  irpcr_pkg::out_item_t          out_data_r, result;

  logic                          accept;
  logic [INTERVAL_BITS-1:0]      tick_inc;
  logic [INTERVAL_BITS-1:0]      rem_dec;
  logic [CNT_W-1:0]              idx_inc;
  logic [31:0]                   tick_ext;
  logic [31:0]                   cnt_ext;
  logic                          ival_ok, cap_done, rep_done;

  logic                          ram_we, ram_re;
  logic [ADDR_W-1:0]             ram_waddr, ram_raddr;
  logic [INTERVAL_BITS-1:0]      ram_rdata;

  irpcr_ram #(
    .WIDTH (INTERVAL_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (tick_inc),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign tick_inc  = (tick_r < TICK_MAX) ? tick_r + 1'b1 : tick_r;
  assign rem_dec   = (rem_r != '0) ? rem_r - 1'b1 : rem_r;
  assign idx_inc   = ridx_r + 1'b1;
  assign tick_ext  = 32'(tick_inc);
  assign cnt_ext   = 32'(count_nxt);
  assign ram_waddr = count_r[ADDR_W-1:0];

  always_comb begin
    last_level_nxt     = last_level_r;
    scanning_nxt       = scanning_r;
    capture_active_nxt = capture_active_r;
    tick_nxt           = tick_r;
    count_nxt          = count_r;
    ridx_nxt           = ridx_r;
    rem_nxt            = rem_r;
    replay_active_nxt  = replay_active_r;
    out_level_nxt      = out_level_r;
    overflow_nxt       = overflow_r;
    entry0_nxt         = entry0_r;
    ram_we             = 1'b0;
    ram_re             = 1'b0;
    ram_raddr          = '0;
    ival_ok            = 1'b0;
    cap_done           = 1'b0;
    rep_done           = 1'b0;
    if (accept) begin
      case (in_data.mode)
        irpcr_pkg::MODE_ARM: begin
          capture_active_nxt = 1'b1;
          scanning_nxt       = 1'b0;
          last_level_nxt     = 1'b1;
          tick_nxt           = '0;
          count_nxt          = '0;
          overflow_nxt       = 1'b0;
          replay_active_nxt  = 1'b0;
          ridx_nxt           = '0;
          rem_nxt            = '0;
          out_level_nxt      = 1'b1;
        end
        irpcr_pkg::MODE_CAP: begin
          if (capture_active_r) begin
            tick_nxt = tick_inc;
            if (in_data.pin_level != last_level_r) begin
              if (scanning_r) begin
                ival_ok = 1'b1;
                if (count_r < DEPTH_CNT) begin
                  ram_we    = 1'b1;
                  count_nxt = count_r + 1'b1;
                  if (count_r == '0) begin
                    entry0_nxt = tick_inc;
                  end
                end else begin
                  overflow_nxt = 1'b1;
                end
              end
              scanning_nxt   = 1'b1;
              tick_nxt       = '0;
              last_level_nxt = in_data.pin_level;
            end else if (scanning_r && (tick_ext > 32'(timeout_r))) begin
              capture_active_nxt = 1'b0;
              cap_done           = 1'b1;
            end
          end
        end
        irpcr_pkg::MODE_REPLAY: begin
          capture_active_nxt = 1'b0;
          ridx_nxt           = '0;
          if (count_r == '0) begin
            replay_active_nxt = 1'b0;
            rem_nxt           = '0;
            out_level_nxt     = 1'b1;
            rep_done          = 1'b1;
          end else begin
            // The first interval comes from its register copy; entry one is
            // fetched now so that it is ready for the next transfer.
            replay_active_nxt = 1'b1;
            out_level_nxt     = 1'b0;
            rem_nxt           = entry0_r;
            ram_re            = 1'b1;
            ram_raddr         = ADDR_W'(1);
          end
        end
        irpcr_pkg::MODE_RTICK: begin
          if (replay_active_r) begin
            rem_nxt = rem_dec;
            if (rem_dec == '0) begin
              ridx_nxt = idx_inc;
              if (idx_inc >= count_r) begin
                replay_active_nxt = 1'b0;
                out_level_nxt     = 1'b1;
                rep_done          = 1'b1;
              end else begin
                // The read data holds the entry at idx_inc since the last fetch.
                out_level_nxt = !out_level_r;
                rem_nxt       = ram_rdata;
                ram_re        = 1'b1;
                ram_raddr     = idx_inc[ADDR_W-1:0] + 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    result.pin_out        = out_level_nxt;
    result.interval       = ival_ok ? tick_ext[irpcr_pkg::INTERVAL_W-1:0] : '0;
    result.interval_valid = ival_ok;
    result.capture_done   = cap_done;
    result.replay_done    = rep_done;
    result.stored_count   = cnt_ext[irpcr_pkg::COUNT_W-1:0];
    result.overflow       = overflow_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r     <= 1'b1;
      scanning_r       <= 1'b0;
      capture_active_r <= 1'b0;
      tick_r           <= '0;
      count_r          <= '0;
      ridx_r           <= '0;
      rem_r            <= '0;
      replay_active_r  <= 1'b0;
      out_level_r      <= 1'b1;
      overflow_r       <= 1'b0;
      timeout_r        <= irpcr_pkg::TIMEOUT_RESET;
      out_valid_r      <= 1'b0;
    end else begin
      last_level_r     <= last_level_nxt;
      scanning_r       <= scanning_nxt;
      capture_active_r <= capture_active_nxt;
      tick_r           <= tick_nxt;
      count_r          <= count_nxt;
      ridx_r           <= ridx_nxt;
      rem_r            <= rem_nxt;
      replay_active_r  <= replay_active_nxt;
      out_level_r      <= out_level_nxt;
      overflow_r       <= overflow_nxt;
      if (cfg_we) begin
        timeout_r <= cfg_wdata;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry0_r <= entry0_nxt;
    if (accept) begin
      out_data_r <= result;
    end
  end

  `IRPCR_ASSERT(a_stall_blocks_input, !(out_valid_r && !out_ready) || !in_ready, "input taken while result stalled")
  `IRPCR_ASSERT(a_count_bound, count_r <= DEPTH_CNT, "interval count beyond store depth")
  `IRPCR_ASSERT(a_replay_index, !replay_active_r || (ridx_r < count_r), "replay index past stored intervals")
  `IRPCR_ASSERT(a_modes_exclusive, !(capture_active_r && replay_active_r), "capture and replay both active")
  `IRPCR_ASSERT_NEXT(a_result_follows, accept, out_valid_r, "no result after an input transfer")

endmodule
